// ===== rtl/efi_pkg.sv =====
// Shared constants and types of the escape-time fractal iterator.
package efi_pkg;

  // Coordinate format: signed, FRAC fraction bits
  localparam int FRAC = 28;
  localparam int CW   = 32;           // coordinate port width
  localparam int LW   = 16;           // iteration count width

  // Shared multiplier: MW x MW signed, one DW-bit digit of b per cycle
  localparam int MW   = 48;
  localparam int PW   = 2 * MW;
  localparam int DW   = 16;
  localparam int ND   = MW / DW;

  // Additive constant and new-z widths
  localparam int KW   = 36;
  localparam int ZW   = 52;

  // Fractal map codes
  localparam logic [2:0] MODE_MANDEL  = 3'd0;
  localparam logic [2:0] MODE_JULIA   = 3'd1;
  localparam logic [2:0] MODE_SHIP    = 3'd2;
  localparam logic [2:0] MODE_BUFFALO = 3'd3;
  localparam logic [2:0] MODE_STAR    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_SHIFT_RE = 2'd2;
  localparam logic [1:0] CFG_SHIFT_IM = 2'd3;

  // Configuration seen by the datapath
  typedef struct packed {
    logic        [2:0]    mode;
    logic        [LW-1:0] limit;
    logic signed [CW-1:0] shift_re;
    logic signed [CW-1:0] shift_im;
  } cfg_t;

endpackage

// ===== rtl/efi_cfg.sv =====
// Configuration register file of the fractal iterator.
module efi_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output efi_pkg::cfg_t         cfg
);
  import efi_pkg::*;

  // Write one register per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_MANDEL;
      cfg.limit    <= LW'(256);
      cfg.shift_re <= '0;
      cfg.shift_im <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE:     cfg.mode     <= cfg_data[2:0];
        CFG_LIMIT:    cfg.limit    <= cfg_data[LW-1:0];
        CFG_SHIFT_RE: cfg.shift_re <= $signed(cfg_data[CW-1:0]);
        CFG_SHIFT_IM: cfg.shift_im <= $signed(cfg_data[CW-1:0]);
        default:      cfg.mode     <= cfg.mode;
      endcase
    end
  end

endmodule

// ===== rtl/efi_mult.sv =====
// Digit-serial signed multiplier shared by all products of the iterator.
module efi_mult (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [efi_pkg::MW-1:0]   a,
  input  logic signed [efi_pkg::MW-1:0]   b,
  output logic                            done,
  output logic signed [efi_pkg::PW-1:0]   prod
);
  import efi_pkg::*;

  localparam int DIW = $clog2(ND);

  logic signed [MW-1:0]   opa;
  logic signed [MW-1:0]   opb;
  logic        [DIW-1:0]  digit;
  logic                   busy;
  logic signed [DW:0]     dig;
  logic signed [MW+DW:0]  pp;
  logic signed [PW-1:0]   pp_sh;

  // Pick the current digit of b: top digit signed, the rest unsigned
  always_comb begin
    if (digit == DIW'(ND - 1)) begin
      dig = {opb[MW-1], opb[MW-1 -: DW]};
    end else begin
      dig = {1'b0, opb[digit*DW +: DW]};
    end
    pp    = opa * dig;
    pp_sh = PW'(pp) <<< (digit * DW);
  end

  // Accumulate one partial product per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      digit <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        digit <= '0;
      end else if (busy) begin
        digit <= digit + DIW'(1);
        if (digit == DIW'(ND - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator carry no reset
  always_ff @(posedge clk) begin
    if (start) begin
      opa  <= a;
      opb  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
  end

endmodule

// ===== rtl/escape_time_fractal_iterator.sv =====
// Each product is issued to the shared 16-bit-digit multiplier, then awaited in S_WAIT.
// An iteration runs 5 products (quadratic maps) or 9 (quintic) plus the S_EVAL and S_CHECK
// states; one that fails the component bound stops at S_CHECK. The result loads once the
// last iteration ends; a zero limit sends the accepted pixel straight to S_DONE.
// One pixel at a time; the next transaction is taken the cycle after the result loads.
// Reset (rst, synchronous) restores register defaults and returns the sequencer to idle.
module escape_time_fractal_iterator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [31:0]           start_re,
  input  logic signed [31:0]           start_im,
  input  logic signed [31:0]           const_re,
  input  logic signed [31:0]           const_im,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [15:0]                  iteration_count,
  output logic                         escaped
);
  import efi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    ST_XX, ST_YY, ST_XY, ST_A2, ST_B2, ST_AB, ST_XPR, ST_YPI, ST_RE2, ST_IM2
  } step_t;

  localparam logic signed [ZW-1:0] TWO  = ZW'(1) <<< (FRAC + 1);
  localparam logic signed [63:0]   FOUR = 64'(1) <<< (2 * FRAC + 2);

  cfg_t                  cfg;
  state_t                state;
  step_t                 step;
  logic [2:0]            mode;
  logic [LW-1:0]         cnt;
  logic                  esc;
  logic signed [CW-1:0]  x, y;
  logic signed [KW-1:0]  kre, kim;
  logic signed [63:0]    pxx, pyy, pxy, sq_re;
  logic signed [MW-1:0]  qp, qq, qr;
  logic signed [79:0]    pre_re, pre_im;
  logic signed [ZW-1:0]  cur_re, cur_im;

  logic                  mul_start, mul_done;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  mul_prod;

  logic                  quint;
  logic signed [MW-1:0]  qa, qb, pr, pi;
  logic signed [65:0]    d, t;
  logic signed [79:0]    neg_im;
  logic signed [ZW-1:0]  re_v, im_v;
  logic signed [KW-1:0]  sre, sim, cre, cim, sre3;
  logic signed [KW-1:0]  kre_v, kim_v;
  logic signed [63:0]    mag;
  logic                  big;

  efi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  efi_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign item_stall = rst || (state != S_IDLE);
  assign quint      = (mode == MODE_STAR);

  // Additive constant from c and the pan offset
  always_comb begin
    sre   = KW'(cfg.shift_re);
    sim   = KW'(cfg.shift_im);
    cre   = KW'(const_re);
    cim   = KW'(const_im);
    sre3  = sre + (sre <<< 1);
    if (cfg.mode == MODE_JULIA) begin
      kre_v = cre + sre;
      kim_v = cim + sim;
    end else begin
      kre_v = cre - (sre3 >>> 1);
      kim_v = cim - sim;
    end
  end

  // Quintic intermediates
  always_comb begin
    qa = MW'(pxx >>> FRAC);
    qb = MW'(pyy >>> FRAC);
    pr = qp - ((qr <<< 3) + (qr <<< 1)) + ((qq <<< 2) + qq);
    pi = ((qp <<< 2) + qp) - ((qr <<< 3) + (qr <<< 1)) + qq;
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = MW'(x);
    mul_b = MW'(x);
    unique case (step)
      ST_XX:   begin mul_a = MW'(x);      mul_b = MW'(x);      end
      ST_YY:   begin mul_a = MW'(y);      mul_b = MW'(y);      end
      ST_XY:   begin mul_a = MW'(x);      mul_b = MW'(y);      end
      ST_A2:   begin mul_a = qa;          mul_b = qa;          end
      ST_B2:   begin mul_a = qb;          mul_b = qb;          end
      ST_AB:   begin mul_a = qa;          mul_b = qb;          end
      ST_XPR:  begin mul_a = MW'(x);      mul_b = pr;          end
      ST_YPI:  begin mul_a = MW'(y);      mul_b = pi;          end
      ST_RE2:  begin mul_a = MW'(cur_re); mul_b = MW'(cur_re); end
      ST_IM2:  begin mul_a = MW'(cur_im); mul_b = MW'(cur_im); end
      default: begin mul_a = MW'(x);      mul_b = MW'(x);      end
    endcase
  end

  assign mul_start = (state == S_ISSUE);

  // Form the new z from the stored products
  always_comb begin
    d = 66'(pxx) - 66'(pyy);
    t = 66'(pxy) <<< 1;
    if (mode == MODE_BUFFALO) begin
      if (d < 0) d = -d;
      if (t > 0) t = -t;
    end
    if (mode == MODE_SHIP && t < 0) t = -t;
    neg_im = -pre_im;
    if (quint) begin
      re_v = ZW'(pre_re >>> FRAC) + ZW'(kre);
      im_v = ZW'(neg_im >>> FRAC) + ZW'(kim);
    end else begin
      re_v = ZW'(d >>> FRAC) + ZW'(kre);
      im_v = ZW'(t >>> FRAC) + ZW'(kim);
    end
  end

  // Escape tests: component bound, then squared magnitude
  assign big = (cur_re > TWO) || (cur_re < -TWO) || (cur_im > TWO) || (cur_im < -TWO);
  assign mag = sq_re + mul_prod[63:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_XX;
      result_valid <= 1'b0;
    end else begin
      // Raise the result when the output register is free, drop it once taken
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            step  <= ST_XX;
            state <= (cfg.limit == '0) ? S_DONE : S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            unique case (step)
              ST_XX:   begin step <= ST_YY;  state <= S_ISSUE; end
              ST_YY:   begin step <= quint ? ST_A2 : ST_XY; state <= S_ISSUE; end
              ST_XY:   state <= S_EVAL;
              ST_A2:   begin step <= ST_B2;  state <= S_ISSUE; end
              ST_B2:   begin step <= ST_AB;  state <= S_ISSUE; end
              ST_AB:   begin step <= ST_XPR; state <= S_ISSUE; end
              ST_XPR:  begin step <= ST_YPI; state <= S_ISSUE; end
              ST_YPI:  state <= S_EVAL;
              ST_RE2:  begin step <= ST_IM2; state <= S_ISSUE; end
              ST_IM2: begin
                if (mag > FOUR || cnt + LW'(1) == cfg.limit) begin
                  state <= S_DONE;
                end else begin
                  state <= S_ISSUE;
                end
                step <= ST_XX;
              end
              default: begin step <= ST_XX; state <= S_ISSUE; end
            endcase
          end
        end
        S_EVAL: state <= S_CHECK;
        S_CHECK: begin
          if (big) begin
            state <= S_DONE;
          end else begin
            step  <= ST_RE2;
            state <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      x    <= start_re;
      y    <= start_im;
      kre  <= kre_v;
      kim  <= kim_v;
      mode <= (cfg.mode > MODE_STAR) ? MODE_MANDEL : cfg.mode;
      cnt  <= '0;
      esc  <= 1'b0;
    end
    if (state == S_WAIT && mul_done) begin
      case (step)
        ST_XX:   pxx    <= mul_prod[63:0];
        ST_YY:   pyy    <= mul_prod[63:0];
        ST_XY:   pxy    <= mul_prod[63:0];
        ST_A2:   qp     <= MW'(mul_prod >>> FRAC);
        ST_B2:   qq     <= MW'(mul_prod >>> FRAC);
        ST_AB:   qr     <= MW'(mul_prod >>> FRAC);
        ST_XPR:  pre_re <= mul_prod[79:0];
        ST_YPI:  pre_im <= mul_prod[79:0];
        ST_RE2:  sq_re  <= mul_prod[63:0];
        ST_IM2: begin
          if (mag > FOUR) begin
            esc <= 1'b1;
          end else begin
            x   <= cur_re[CW-1:0];
            y   <= cur_im[CW-1:0];
            cnt <= cnt + LW'(1);
          end
        end
        default: pxx <= pxx;
      endcase
    end
    if (state == S_EVAL) begin
      cur_re <= re_v;
      cur_im <= im_v;
    end
    if (state == S_CHECK && big) esc <= 1'b1;
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      iteration_count <= cnt;
      escaped         <= esc;
    end
  end

endmodule

// ===== rtl/efi_checker.sv =====
// Port-level checker for the fractal iterator, bound to the top level.
module efi_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] iteration_count,
  input logic        escaped
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(iteration_count)
      && $stable(escaped))
    else $error("stalled result changed");

  // Block new transactions while a pixel is in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second transaction taken during work");

  // A result never appears in the cycle right after acceptance
  a_lat: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> !$rose(result_valid))
    else $error("result too early");

  // Reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind escape_time_fractal_iterator efi_checker u_efi_checker (.*);
